>>> sv/next_greater_distance_stack_top_defines.svh
// ----------------------------------------------------------------------------
// next_greater_distance_stack_top_defines.svh
// Assertion macros used by nged_back of the next-greater-distance stack.
// ----------------------------------------------------------------------------
`ifndef NEXT_GREATER_DISTANCE_STACK_TOP_DEFINES_SVH
`define NEXT_GREATER_DISTANCE_STACK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NGED_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NGED_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nged_pkg.sv
// ----------------------------------------------------------------------------
// nged_pkg
// Shared constants and types of the next-greater-distance stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nged_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int POS_W           = 6;
    localparam int QUEUE_DEPTH     = 4;

    // Classification that the front attaches to each queued sample
    typedef struct packed {
        logic             seq_end;
        logic             ovf;
        logic [POS_W-1:0] pos;
    } ctl_t;

endpackage

>>> sv/next_greater_distance_stack_top.sv
// ----------------------------------------------------------------------------
// next_greater_distance_stack_top
// For each sample of a sequence, reports how many positions later a strictly
// greater sample arrives. The front takes a sample in any cycle the four-entry
// queue has room. For each sample the back pops and reports every pending
// entry it resolves, then pushes the sample; at the end of a sequence it
// flushes every pending entry and then closes the sequence. A dropped sample
// with nothing pending gives a lone overflow result. The pace of the back is
// set by the single read port of the stack RAM, which delivers one entry below
// the top per cycle while the result side does not stall. A result for a
// sample appears once the next result of the same item is known or the item
// completes, so that its run_last flag is exact.
// Samples past MAX_LEN in one sequence are dropped with an overflow result.
// The stack RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_greater_distance_stack_top #(
    parameter int MAX_LEN     = nged_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = nged_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          seq_end,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [nged_pkg::POS_W-1:0]    position,
    output logic [nged_pkg::POS_W-1:0]    wait_count,
    output logic                          run_last,
    output logic                          overflow
);

    localparam int CTL_W = $bits(nged_pkg::ctl_t);
    localparam int QW    = SAMPLE_BITS + CTL_W;

    logic                   q_push, q_full, q_pop, q_empty;
    logic [SAMPLE_BITS-1:0] f_sample;
    nged_pkg::ctl_t         f_ctl;
    logic [QW-1:0]          q_rdata;
    nged_pkg::ctl_t         b_ctl;

    nged_front #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sample     (sample),
        .seq_end    (seq_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_sample   (f_sample),
        .q_ctl      (f_ctl)
    );

    nged_fifo #(
        .WIDTH (QW),
        .DEPTH (nged_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_sample, f_ctl}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign b_ctl = q_rdata[CTL_W-1:0];

    nged_back #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_sample     (q_rdata[QW-1:CTL_W]),
        .q_ctl        (b_ctl),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .position     (position),
        .wait_count   (wait_count),
        .run_last     (run_last),
        .overflow     (overflow)
    );

endmodule

>>> sv/nged_ram.sv
// ----------------------------------------------------------------------------
// nged_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nged_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/nged_fifo.sv
// ----------------------------------------------------------------------------
// nged_fifo
// Short flop-based queue between the front and the back of the stack unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nged_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/nged_front.sv
// ----------------------------------------------------------------------------
// nged_front
// Accepts samples, numbers them within the sequence and flags overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nged_front #(
    parameter int MAX_LEN     = nged_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = nged_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          seq_end,
    input  logic                          q_full,
    output logic                          q_push,
    output logic        [SAMPLE_BITS-1:0] q_sample,
    output nged_pkg::ctl_t                q_ctl
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = nged_pkg::POS_W;

    logic [CW-1:0] next_pos_reg, next_pos_next;
    logic          accept;
    logic          is_ovf;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign is_ovf     = (next_pos_reg >= CW'(MAX_LEN));

    assign q_push      = accept;
    assign q_sample    = sample;
    assign q_ctl.seq_end = seq_end;
    assign q_ctl.ovf   = is_ovf;
    assign q_ctl.pos   = PW'(next_pos_reg);

    always_comb
    begin
        next_pos_next = next_pos_reg;
        if (accept)
        begin
            // a dropped sample keeps the count unless it closes the sequence
            if (seq_end)
            begin
                next_pos_next = '0;
            end
            else if (!is_ovf)
            begin
                next_pos_next = next_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_pos_reg <= '0;
        end
        else
        begin
            next_pos_reg <= next_pos_next;
        end
    end

endmodule

>>> sv/nged_back.sv
// ----------------------------------------------------------------------------
// nged_back
// Runs the monotonic stack: pops resolved entries, pushes the new sample,
// flushes at sequence end and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "next_greater_distance_stack_top_defines.svh"

module nged_back #(
    parameter int MAX_LEN     = nged_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = nged_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  logic       [SAMPLE_BITS-1:0] q_sample,
    input  nged_pkg::ctl_t               q_ctl,
    output logic                         q_pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [nged_pkg::POS_W-1:0]   position,
    output logic [nged_pkg::POS_W-1:0]   wait_count,
    output logic                         run_last,
    output logic                         overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = nged_pkg::POS_W;
    localparam int EW = PW + SAMPLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_END
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    top_ram_reg, top_ram_next;
    logic signed [SAMPLE_BITS-1:0] top_val_reg, top_val_next;
    logic [PW-1:0]           top_pos_reg, top_pos_next;
    logic signed [SAMPLE_BITS-1:0] cur_val_reg, cur_val_next;
    logic [PW-1:0]           cur_pos_reg, cur_pos_next;
    logic                    cur_last_reg, cur_last_next;
    logic                    cur_ovf_reg, cur_ovf_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic [PW-1:0]           hold_pos_reg, hold_pos_next;
    logic [PW-1:0]           hold_wait_reg, hold_wait_next;
    logic                    hold_ovf_reg, hold_ovf_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PW-1:0]           out_pos_reg, out_pos_next;
    logic [PW-1:0]           out_wait_reg, out_wait_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_ovf_reg, out_ovf_next;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [EW-1:0]           ram_wdata, ram_rdata;

    logic signed [SAMPLE_BITS-1:0] top_v;
    logic [PW-1:0]           top_p;
    logic [CW-1:0]           cnt_m1, cnt_m2;
    logic                    has_top, out_free, emit_ok;
    logic                    emit, pop_stack, push_stack, do_final, finish;
    logic [PW-1:0]           emit_pos, emit_wait;
    logic                    emit_ovf;

    nged_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LEN)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // top of stack sits in the top register or, right after a pop, in the RAM read data
    assign top_v    = top_ram_reg ? $signed(ram_rdata[EW-1:PW]) : top_val_reg;
    assign top_p    = top_ram_reg ? ram_rdata[PW-1:0] : top_pos_reg;
    assign cnt_m1   = cnt_reg - 1'b1;
    assign cnt_m2   = cnt_reg - CW'(2);
    assign has_top  = (cnt_reg != '0);
    assign out_free = !out_valid_reg || !result_stall;
    assign emit_ok  = !hold_valid_reg || out_free;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        top_ram_next    = top_ram_reg;
        top_val_next    = top_val_reg;
        top_pos_next    = top_pos_reg;
        cur_val_next    = cur_val_reg;
        cur_pos_next    = cur_pos_reg;
        cur_last_next   = cur_last_reg;
        cur_ovf_next    = cur_ovf_reg;
        hold_valid_next = hold_valid_reg;
        hold_pos_next   = hold_pos_reg;
        hold_wait_next  = hold_wait_reg;
        hold_ovf_next   = hold_ovf_reg;
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_wait_next   = out_wait_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = cnt_m1[AW-1:0];
        ram_raddr       = cnt_m2[AW-1:0];
        ram_wdata       = {top_v, top_p};
        q_pop           = 1'b0;
        emit            = 1'b0;
        pop_stack       = 1'b0;
        push_stack      = 1'b0;
        do_final        = 1'b0;
        finish          = 1'b0;
        emit_pos        = top_p;
        emit_wait       = '0;
        emit_ovf        = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                finish = 1'b1;
            end
            S_SCAN:
            begin
                if (has_top && (top_v < cur_val_reg))
                begin
                    if (emit_ok)
                    begin
                        emit      = 1'b1;
                        emit_wait = cur_pos_reg - top_p;
                        pop_stack = 1'b1;
                    end
                end
                else
                begin
                    push_stack = 1'b1;
                    if (cur_last_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        do_final = 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (has_top)
                begin
                    if (emit_ok)
                    begin
                        emit      = 1'b1;
                        emit_ovf  = cur_ovf_reg;
                        pop_stack = 1'b1;
                    end
                end
                else
                begin
                    do_final = 1'b1;
                end
            end
            S_END:
            begin
                do_final = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance the stack pointer and prefetch the entry below the popped one
        if (pop_stack)
        begin
            cnt_next = cnt_m1;
            if (cnt_reg >= CW'(2))
            begin
                ram_re       = 1'b1;
                top_ram_next = 1'b1;
            end
        end

        // spill the old top to RAM and keep the new sample in the top register
        if (push_stack && (cnt_reg != CW'(MAX_LEN)))
        begin
            ram_we       = has_top;
            top_val_next = cur_val_reg;
            top_pos_next = cur_pos_reg;
            top_ram_next = 1'b0;
            cnt_next     = cnt_reg + 1'b1;
        end

        // a new result displaces the held one; only the item's final result is marked last
        if (emit)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_pos_next   = hold_pos_reg;
                out_wait_next  = hold_wait_reg;
                out_last_next  = 1'b0;
                out_ovf_next   = hold_ovf_reg;
            end
            hold_valid_next = 1'b1;
            hold_pos_next   = emit_pos;
            hold_wait_next  = emit_wait;
            hold_ovf_next   = emit_ovf;
        end

        if (do_final)
        begin
            if (hold_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pos_next    = hold_pos_reg;
                    out_wait_next   = hold_wait_reg;
                    out_last_next   = 1'b1;
                    out_ovf_next    = hold_ovf_reg;
                    hold_valid_next = 1'b0;
                    finish          = 1'b1;
                end
            end
            else if (cur_ovf_reg)
            begin
                // dropped sample with nothing pending
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = '0;
                    out_wait_next  = '0;
                    out_last_next  = 1'b1;
                    out_ovf_next   = 1'b1;
                    finish         = 1'b1;
                end
            end
            else
            begin
                finish = 1'b1;
            end
            if (!finish)
            begin
                state_next = S_END;
            end
        end

        if (finish)
        begin
            if (!q_empty)
            begin
                q_pop         = 1'b1;
                cur_val_next  = $signed(q_sample);
                cur_pos_next  = q_ctl.pos;
                cur_last_next = q_ctl.seq_end;
                cur_ovf_next  = q_ctl.ovf;
                if (q_ctl.ovf)
                begin
                    state_next = q_ctl.seq_end ? S_FLUSH : S_END;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            top_ram_reg    <= 1'b0;
            top_val_reg    <= '0;
            top_pos_reg    <= '0;
            cur_val_reg    <= '0;
            cur_pos_reg    <= '0;
            cur_last_reg   <= 1'b0;
            cur_ovf_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_pos_reg   <= '0;
            hold_wait_reg  <= '0;
            hold_ovf_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_wait_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            top_ram_reg    <= top_ram_next;
            top_val_reg    <= top_val_next;
            top_pos_reg    <= top_pos_next;
            cur_val_reg    <= cur_val_next;
            cur_pos_reg    <= cur_pos_next;
            cur_last_reg   <= cur_last_next;
            cur_ovf_reg    <= cur_ovf_next;
            hold_valid_reg <= hold_valid_next;
            hold_pos_reg   <= hold_pos_next;
            hold_wait_reg  <= hold_wait_next;
            hold_ovf_reg   <= hold_ovf_next;
            out_valid_reg  <= out_valid_next;
            out_pos_reg    <= out_pos_next;
            out_wait_reg   <= out_wait_next;
            out_last_reg   <= out_last_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign position     = out_pos_reg;
    assign wait_count   = out_wait_reg;
    assign run_last     = out_last_reg;
    assign overflow     = out_ovf_reg;

    `NGED_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_LEN), "stack depth beyond MAX_LEN")
    `NGED_ASSERT_NEXT(a_cnt_step, clk, rst_n, 1'b1, (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 1'b1) || (cnt_reg == $past(cnt_reg) - 1'b1), "stack depth moved by more than one")
    `NGED_ASSERT_NOW(a_ovf_wait, clk, rst_n, result_valid && overflow, wait_count == '0, "overflow result with nonzero wait")
    `NGED_ASSERT_NOW(a_idle_hold, clk, rst_n, state_reg == S_IDLE, !hold_valid_reg, "held result left behind at idle")

endmodule

>>> verif/next_greater_distance_stack_top_tb.sv
// ----------------------------------------------------------------------------
// next_greater_distance_stack_top_tb
// Drives sequences of signed samples into the next-greater-distance stack and
// checks every result against a local model of the pending stack or, for a
// typed row, its own entry. A short table of hand-picked samples opens the
// run, then random sequences, full-depth and overflowing ones among them, under
// random idling on both channels, one long result hold-off and one drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_greater_distance_stack_top_tb;

    localparam int SEQ_MAX     = nged_pkg::MAX_LEN_DEF;
    localparam int VAL_W       = nged_pkg::SAMPLE_BITS_DEF;
    localparam int POS_W       = nged_pkg::POS_W;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] gap;
        logic             run_end;
        logic             ovf;
    } nged_result_t;

    typedef struct {
        logic signed [VAL_W-1:0] s;
        logic                    e;
        bit                      typed;
        int                      n;
        nged_result_t            r;
    } step_row_t;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    item_valid   = 1'b0;
    logic                    item_stall;
    logic signed [VAL_W-1:0] sample       = '0;
    logic                    seq_end      = 1'b0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        wait_count;
    logic                    run_last;
    logic                    overflow;

    // Model of the pending stack
    logic [POS_W-1:0]        stack_pos [0:SEQ_MAX-1];
    logic signed [VAL_W-1:0] stack_val [0:SEQ_MAX-1];
    int                      stack_depth = 0;
    int                      seq_pos     = 0;

    nged_result_t            fresh_q [$];
    nged_result_t            distance_q [$];
    step_row_t               plan [$];

    int                      mismatches = 0;
    int                      sent       = 0;
    bit                      idle_on    = 1'b1;
    bit                      hold_req   = 1'b0;

    next_greater_distance_stack_top #(
        .MAX_LEN     (SEQ_MAX),
        .SAMPLE_BITS (VAL_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .sample       (sample),
        .seq_end      (seq_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .position     (position),
        .wait_count   (wait_count),
        .run_last     (run_last),
        .overflow     (overflow)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #(5_000_000);
        $display("next_greater_distance_stack_top_tb failed");
        $finish;
    end

    // Emit every pending entry from the top down and start a new sequence.
    function automatic void flush_pending(input logic ovf);
        nged_result_t r;
        while (stack_depth > 0)
        begin
            stack_depth--;
            r = '{pos: stack_pos[stack_depth], gap: '0, run_end: 1'b0, ovf: ovf};
            fresh_q = {fresh_q, r};
        end
        seq_pos = 0;
    endfunction

    // Work out the results of one accepted sample into fresh_q.
    function automatic void resolve_sample(input logic signed [VAL_W-1:0] s, input logic e);
        nged_result_t r;
        fresh_q.delete();
        if (seq_pos >= SEQ_MAX)
        begin
            if (e)
                flush_pending(1'b1);
            if (fresh_q.size() == 0)
            begin
                r = '{pos: '0, gap: '0, run_end: 1'b1, ovf: 1'b1};
                fresh_q = {fresh_q, r};
            end
        end
        else
        begin
            while (stack_depth > 0 && stack_val[stack_depth-1] < s)
            begin
                r = '{pos: stack_pos[stack_depth-1],
                      gap: POS_W'(seq_pos - int'(stack_pos[stack_depth-1])),
                      run_end: 1'b0, ovf: 1'b0};
                fresh_q = {fresh_q, r};
                stack_depth--;
            end
            if (stack_depth < SEQ_MAX)
            begin
                stack_pos[stack_depth] = POS_W'(seq_pos);
                stack_val[stack_depth] = s;
                stack_depth++;
            end
            seq_pos++;
            if (e)
                flush_pending(1'b0);
        end
        if (fresh_q.size() > 0)
        begin
            r = fresh_q[fresh_q.size()-1];
            r.run_end = 1'b1;
            fresh_q[fresh_q.size()-1] = r;
        end
    endfunction

    function automatic void add_row(input int s, input logic e, input bit typed, input int n,
                                    input int pos, input int gap, input logic re,
                                    input logic ovf);
        step_row_t row;
        row.s     = VAL_W'(s);
        row.e     = e;
        row.typed = typed;
        row.n     = n;
        row.r     = '{pos: POS_W'(pos), gap: POS_W'(gap), run_end: re, ovf: ovf};
        plan = {plan, row};
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_sample(input int mode, input int prev);
        logic signed [VAL_W-1:0] raw;
        int v;
        raw = VAL_W'($urandom);
        case (mode)
            1:       v = int'($urandom_range(6)) - 3;
            2:       v = prev - int'($urandom_range(300));
            3:       v = prev + int'($urandom_range(300));
            default: v = raw;
        endcase
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return VAL_W'(v);
    endfunction

    // Offer one sample, hold it until the transfer, then queue its results.
    task automatic send_item(input logic signed [VAL_W-1:0] s, input logic e, input bit typed,
                             input int n, input nged_result_t r);
        while (idle_on && $urandom_range(99) < 36)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        sample     <= s;
        seq_end    <= e;
        do
            @(posedge clk);
        while (item_stall);
        sent++;
        resolve_sample(s, e);
        if (typed)
        begin
            if (n > 0)
                distance_q = {distance_q, r};
        end
        else
        begin
            foreach (fresh_q[k])
                distance_q = {distance_q, fresh_q[k]};
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (idle_on)
                result_stall <= ($urandom_range(99) < 36);
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        nged_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (distance_q.size() == 0)
            begin
                $error("unexpected result: position %0d wait_count %0d", position, wait_count);
                mismatches++;
            end
            else
            begin
                want = distance_q.pop_front();
                if (position !== want.pos)
                begin
                    $error("position: expected %0d, got %0d", want.pos, position);
                    mismatches++;
                end
                if (wait_count !== want.gap)
                begin
                    $error("wait_count: expected %0d, got %0d", want.gap, wait_count);
                    mismatches++;
                end
                if (run_last !== want.run_end)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_end, run_last);
                    mismatches++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int len;
        int mode;
        int prev;
        int seq_idx;
        int target;
        logic signed [VAL_W-1:0] s;
        nged_result_t none;

        none = '0;

        // sample, seq_end, typed, count, position, wait_count, run_last, overflow
        add_row(-32768, 1'b1, 1'b1, 1, 0, 0, 1'b1, 1'b0);
        add_row( 32767, 1'b0, 1'b1, 0, 0, 0, 1'b0, 1'b0);
        add_row( 32767, 1'b0, 1'b1, 0, 0, 0, 1'b0, 1'b0);
        add_row(-32768, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(     0, 1'b0, 1'b1, 0, 0, 0, 1'b0, 1'b0);
        add_row(     1, 1'b0, 1'b1, 1, 0, 1, 1'b1, 1'b0);
        add_row(     1, 1'b0, 1'b1, 0, 0, 0, 1'b0, 1'b0);
        add_row(     2, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(     5, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(     4, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(     3, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(    -1, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row( 32767, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row( 21845, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(-21846, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(-21846, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row( 21845, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_item(plan[k].s, plan[k].e, plan[k].typed, plan[k].n, plan[k].r);

        target  = sent + RANDOM_ITEMS;
        seq_idx = 0;
        while (sent < target)
        begin
            idle_on = !(seq_idx >= 30 && seq_idx < 45);
            if (seq_idx == 10)
                hold_req = 1'b1;
            // Drain pause: hold the input until every result is out.
            if (seq_idx == 20 && distance_q.size() != 0)
            begin
                item_valid <= 1'b0;
                while (distance_q.size() != 0)
                    @(posedge clk);
            end

            if (seq_idx == 2)
            begin
                // Full non-increasing stack, flushed by the last sample.
                for (i = 0; i < SEQ_MAX; i++)
                    send_item(VAL_W'(32767 - (i / 2) * 1000), i == SEQ_MAX - 1, 1'b0, 0, none);
            end
            else if (seq_idx == 5)
            begin
                // Overflow without end, then overflow at end.
                for (i = 0; i < SEQ_MAX; i++)
                    send_item(pick_sample(0, 0), 1'b0, 1'b0, 0, none);
                send_item(pick_sample(0, 0), 1'b0, 1'b0, 0, none);
                send_item(pick_sample(0, 0), 1'b0, 1'b0, 0, none);
                send_item(pick_sample(0, 0), 1'b1, 1'b0, 0, none);
            end
            else if (seq_idx == 33)
            begin
                prev = -32768;
                for (i = 0; i < SEQ_MAX; i++)
                begin
                    s    = pick_sample(3, prev);
                    prev = s;
                    send_item(s, 1'b0, 1'b0, 0, none);
                end
                send_item(pick_sample(0, 0), 1'b1, 1'b0, 0, none);
            end
            else
            begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
                mode = $urandom_range(3);
                prev = pick_sample(0, 0);
                for (i = 0; i < len; i++)
                begin
                    s    = pick_sample(mode, prev);
                    prev = s;
                    send_item(s, i == len - 1, 1'b0, 0, none);
                end
            end
            seq_idx++;
        end
        idle_on = 1'b1;
        item_valid <= 1'b0;

        while (distance_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && distance_q.size() == 0)
            $display("next_greater_distance_stack_top_tb passed");
        else
            $display("next_greater_distance_stack_top_tb failed");
        $finish;
    end

endmodule
